[src/cse_pkg.sv]
// Shared types, codes and constants for the 8080 subset executor.
package cse_pkg;

    // Byte memory size and its address width.
    localparam int unsigned MEM_DEPTH = 65536;
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNIMP  = 2'd1;
    localparam logic [1:0] ST_HALTED = 2'd2;

    // Input item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EXEC = 1'b1;

    // Opcodes of the implemented set.
    localparam logic [7:0] OP_NOP0  = 8'h00;
    localparam logic [7:0] OP_NOP1  = 8'h08;
    localparam logic [7:0] OP_NOP2  = 8'h10;
    localparam logic [7:0] OP_NOP3  = 8'h18;
    localparam logic [7:0] OP_NOP4  = 8'h20;
    localparam logic [7:0] OP_NOP5  = 8'h28;
    localparam logic [7:0] OP_NOP6  = 8'h30;
    localparam logic [7:0] OP_NOP7  = 8'h38;
    localparam logic [7:0] OP_LXI_B = 8'h01;
    localparam logic [7:0] OP_LXI_D = 8'h11;
    localparam logic [7:0] OP_LXI_H = 8'h21;
    localparam logic [7:0] OP_LXI_SP = 8'h31;
    localparam logic [7:0] OP_STAX_B = 8'h02;
    localparam logic [7:0] OP_STAX_D = 8'h12;
    localparam logic [7:0] OP_LDAX_B = 8'h0A;
    localparam logic [7:0] OP_LDAX_D = 8'h1A;
    localparam logic [7:0] OP_INX_B = 8'h03;
    localparam logic [7:0] OP_INX_D = 8'h13;
    localparam logic [7:0] OP_DCX_B = 8'h0B;
    localparam logic [7:0] OP_DCX_D = 8'h1B;
    localparam logic [7:0] OP_INR_B = 8'h04;
    localparam logic [7:0] OP_INR_C = 8'h0C;
    localparam logic [7:0] OP_INR_D = 8'h14;
    localparam logic [7:0] OP_INR_E = 8'h1C;
    localparam logic [7:0] OP_INR_H = 8'h24;
    localparam logic [7:0] OP_INR_L = 8'h2C;
    localparam logic [7:0] OP_INR_M = 8'h34;
    localparam logic [7:0] OP_INR_A = 8'h3C;
    localparam logic [7:0] OP_DCR_B = 8'h05;
    localparam logic [7:0] OP_DCR_C = 8'h0D;
    localparam logic [7:0] OP_DCR_D = 8'h15;
    localparam logic [7:0] OP_DCR_E = 8'h1D;
    localparam logic [7:0] OP_MVI_B = 8'h06;
    localparam logic [7:0] OP_MVI_C = 8'h0E;
    localparam logic [7:0] OP_MVI_D = 8'h16;
    localparam logic [7:0] OP_MVI_E = 8'h1E;
    localparam logic [7:0] OP_RLC   = 8'h07;
    localparam logic [7:0] OP_RRC   = 8'h0F;
    localparam logic [7:0] OP_RAL   = 8'h17;
    localparam logic [7:0] OP_RAR   = 8'h1F;
    localparam logic [7:0] OP_DAD_B = 8'h09;
    localparam logic [7:0] OP_DAD_D = 8'h19;
    localparam logic [7:0] OP_MOV_BC = 8'h41;
    localparam logic [7:0] OP_MOV_BD = 8'h42;
    localparam logic [7:0] OP_MOV_BE = 8'h43;

    // Register codes held in opcode bits 5:3.
    localparam logic [2:0] R_B = 3'd0;
    localparam logic [2:0] R_C = 3'd1;
    localparam logic [2:0] R_D = 3'd2;
    localparam logic [2:0] R_E = 3'd3;
    localparam logic [2:0] R_H = 3'd4;
    localparam logic [2:0] R_L = 3'd5;

    // Input item.
    typedef struct packed {
        logic        kind;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] prog_counter;
        logic [15:0] stack_ptr;
        logic [7:0]  accum;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
        logic [4:0]  flag_bits;
        logic [3:0]  state_count;
    } out_item_t;

    // Classified entry passed from the front end to the execution unit.
    typedef struct packed {
        logic        is_exec;
        logic [15:0] addr;
        logic [7:0]  data;
    } queue_entry_t;

    // Flags after an increment or decrement: S Z AC P CY.
    function automatic logic [4:0] incdec_flags(input logic [7:0] r, input logic ac,
                                                input logic cy);
        incdec_flags = {r[7], (r == 8'h00), ac, ~^r, cy};
    endfunction

endpackage

[src/cse_front.sv]
// Front end: accepts input transfers, classifies them and queues them.
module cse_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cse_pkg::in_item_t     s_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output cse_pkg::queue_entry_t q_entry
);
    cse_pkg::queue_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    // Two-entry queue handshake.
    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify the item as it is stored.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].is_exec <= (s_data.kind == cse_pkg::KIND_EXEC);
            slot_reg[wr_ptr_reg].addr    <= s_data.load_address;
            slot_reg[wr_ptr_reg].data    <= s_data.load_data;
        end
    end
endmodule

[src/cse_back.sv]
// Execution unit: byte memory, register file, instruction sequencer, result register.
module cse_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  cse_pkg::queue_entry_t q_entry,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cse_pkg::out_item_t    m_data
);
    typedef enum logic [2:0] {S_IDLE, S_B1, S_B2, S_EXEC, S_MEMRD, S_DONE} state_t;

    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] bc_reg, bc_next;
    logic [15:0] de_reg, de_next;
    logic [15:0] hl_reg, hl_next;
    logic [7:0]  a_reg, a_next;
    logic [4:0]  flags_reg, flags_next;
    logic        halted_reg, halted_next;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  b1_reg, b1_next;
    logic        m_valid_reg, m_valid_next;
    cse_pkg::out_item_t m_data_reg, m_data_next;

    logic [7:0]  mem [cse_pkg::MEM_DEPTH];
    logic [7:0]  rdata_reg;
    logic [15:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    logic [15:0] pair_sel;
    logic [7:0]  reg_val, reg_inc, reg_dec, mem_inc;
    logic [16:0] dad_sum;
    logic        out_free;

    assign q_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Single-port memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr[cse_pkg::MEM_AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr[cse_pkg::MEM_AW-1:0]];
    end

    // Operand selection for the current opcode.
    always_comb begin
        pair_sel = op_reg[4] ? de_reg : bc_reg;
        case (op_reg[5:3])
            cse_pkg::R_B: reg_val = bc_reg[15:8];
            cse_pkg::R_C: reg_val = bc_reg[7:0];
            cse_pkg::R_D: reg_val = de_reg[15:8];
            cse_pkg::R_E: reg_val = de_reg[7:0];
            cse_pkg::R_H: reg_val = hl_reg[15:8];
            cse_pkg::R_L: reg_val = hl_reg[7:0];
            default:      reg_val = a_reg;
        endcase
        reg_inc = reg_val + 8'd1;
        reg_dec = reg_val - 8'd1;
        mem_inc = rdata_reg + 8'd1;
        dad_sum = {1'b0, hl_reg} + {1'b0, pair_sel};
    end

    // Sequencer next-state and datapath.
    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        sp_next      = sp_reg;
        bc_next      = bc_reg;
        de_next      = de_reg;
        hl_next      = hl_reg;
        a_next       = a_reg;
        flags_next   = flags_reg;
        halted_next  = halted_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        b1_next      = b1_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_addr     = pc_reg;
        mem_we       = 1'b0;
        mem_wdata    = q_entry.data;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    count_next  = 4'd0;
                    status_next = halted_reg ? cse_pkg::ST_HALTED : cse_pkg::ST_OK;
                    if (!q_entry.is_exec) begin
                        mem_addr   = q_entry.addr;
                        mem_we     = 1'b1;
                        state_next = S_DONE;
                    end else if (halted_reg) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_B1;
                    end
                end
            end
            S_B1: begin
                op_next    = rdata_reg;
                mem_addr   = pc_reg + 16'd1;
                state_next = S_B2;
            end
            S_B2: begin
                b1_next    = rdata_reg;
                mem_addr   = pc_reg + 16'd2;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                pc_next    = pc_reg + 16'd1;
                case (op_reg) inside
                    cse_pkg::OP_NOP0, cse_pkg::OP_NOP1, cse_pkg::OP_NOP2,
                    cse_pkg::OP_NOP3, cse_pkg::OP_NOP4, cse_pkg::OP_NOP5,
                    cse_pkg::OP_NOP6, cse_pkg::OP_NOP7: begin
                        count_next = 4'd4;
                    end
                    cse_pkg::OP_LXI_B, cse_pkg::OP_LXI_D, cse_pkg::OP_LXI_H,
                    cse_pkg::OP_LXI_SP: begin
                        // Third byte arrives on the read port now.
                        case (op_reg)
                            cse_pkg::OP_LXI_B:  bc_next = {rdata_reg, b1_reg};
                            cse_pkg::OP_LXI_D:  de_next = {rdata_reg, b1_reg};
                            cse_pkg::OP_LXI_H:  hl_next = {rdata_reg, b1_reg};
                            default:            sp_next = {rdata_reg, b1_reg};
                        endcase
                        pc_next    = pc_reg + 16'd3;
                        count_next = 4'd10;
                    end
                    cse_pkg::OP_STAX_B, cse_pkg::OP_STAX_D: begin
                        mem_addr   = pair_sel;
                        mem_we     = 1'b1;
                        mem_wdata  = a_reg;
                        count_next = 4'd7;
                    end
                    cse_pkg::OP_LDAX_B, cse_pkg::OP_LDAX_D: begin
                        mem_addr   = pair_sel;
                        pc_next    = pc_reg;
                        count_next = 4'd7;
                        state_next = S_MEMRD;
                    end
                    cse_pkg::OP_INR_M: begin
                        mem_addr   = hl_reg;
                        pc_next    = pc_reg;
                        count_next = 4'd10;
                        state_next = S_MEMRD;
                    end
                    cse_pkg::OP_INX_B, cse_pkg::OP_INX_D, cse_pkg::OP_DCX_B,
                    cse_pkg::OP_DCX_D: begin
                        if (op_reg[4]) begin
                            de_next = op_reg[3] ? de_reg - 16'd1 : de_reg + 16'd1;
                        end else begin
                            bc_next = op_reg[3] ? bc_reg - 16'd1 : bc_reg + 16'd1;
                        end
                        count_next = 4'd5;
                    end
                    cse_pkg::OP_INR_B, cse_pkg::OP_INR_C, cse_pkg::OP_INR_D,
                    cse_pkg::OP_INR_E, cse_pkg::OP_INR_H, cse_pkg::OP_INR_L,
                    cse_pkg::OP_INR_A, cse_pkg::OP_DCR_B, cse_pkg::OP_DCR_C,
                    cse_pkg::OP_DCR_D, cse_pkg::OP_DCR_E: begin
                        logic [7:0] res;
                        // Bit 0 of the opcode tells decrement from increment.
                        if (op_reg[0]) begin
                            res        = reg_dec;
                            flags_next = cse_pkg::incdec_flags(res, res[3:0] != 4'hF,
                                                               flags_reg[0]);
                        end else begin
                            res        = reg_inc;
                            flags_next = cse_pkg::incdec_flags(res, res[3:0] == 4'h0,
                                                               flags_reg[0]);
                        end
                        case (op_reg[5:3])
                            cse_pkg::R_B: bc_next[15:8] = res;
                            cse_pkg::R_C: bc_next[7:0]  = res;
                            cse_pkg::R_D: de_next[15:8] = res;
                            cse_pkg::R_E: de_next[7:0]  = res;
                            cse_pkg::R_H: hl_next[15:8] = res;
                            cse_pkg::R_L: hl_next[7:0]  = res;
                            default:      a_next        = res;
                        endcase
                        count_next = 4'd5;
                    end
                    cse_pkg::OP_MVI_B, cse_pkg::OP_MVI_C, cse_pkg::OP_MVI_D,
                    cse_pkg::OP_MVI_E: begin
                        case (op_reg[5:3])
                            cse_pkg::R_B: bc_next[15:8] = b1_reg;
                            cse_pkg::R_C: bc_next[7:0]  = b1_reg;
                            cse_pkg::R_D: de_next[15:8] = b1_reg;
                            default:      de_next[7:0]  = b1_reg;
                        endcase
                        pc_next    = pc_reg + 16'd2;
                        count_next = 4'd7;
                    end
                    cse_pkg::OP_RLC: begin
                        a_next        = {a_reg[6:0], a_reg[7]};
                        flags_next[0] = a_reg[7];
                        count_next    = 4'd4;
                    end
                    cse_pkg::OP_RRC: begin
                        a_next        = {a_reg[0], a_reg[7:1]};
                        flags_next[0] = a_reg[0];
                        count_next    = 4'd4;
                    end
                    cse_pkg::OP_RAL: begin
                        a_next        = {a_reg[6:0], flags_reg[0]};
                        flags_next[0] = a_reg[7];
                        count_next    = 4'd4;
                    end
                    cse_pkg::OP_RAR: begin
                        a_next        = {flags_reg[0], a_reg[7:1]};
                        flags_next[0] = a_reg[0];
                        count_next    = 4'd4;
                    end
                    cse_pkg::OP_DAD_B, cse_pkg::OP_DAD_D: begin
                        hl_next       = dad_sum[15:0];
                        flags_next[0] = dad_sum[16];
                        count_next    = 4'd10;
                    end
                    cse_pkg::OP_MOV_BC, cse_pkg::OP_MOV_BD, cse_pkg::OP_MOV_BE: begin
                        case (op_reg)
                            cse_pkg::OP_MOV_BC: bc_next[15:8] = bc_reg[7:0];
                            cse_pkg::OP_MOV_BD: bc_next[15:8] = de_reg[15:8];
                            default:            bc_next[15:8] = de_reg[7:0];
                        endcase
                        count_next = 4'd5;
                    end
                    default: begin
                        // Unimplemented opcode: PC stays, block halts.
                        pc_next     = pc_reg;
                        halted_next = 1'b1;
                        status_next = cse_pkg::ST_UNIMP;
                        count_next  = 4'd0;
                    end
                endcase
            end
            S_MEMRD: begin
                pc_next    = pc_reg + 16'd1;
                state_next = S_DONE;
                if (op_reg == cse_pkg::OP_INR_M) begin
                    mem_addr   = hl_reg;
                    mem_we     = 1'b1;
                    mem_wdata  = mem_inc;
                    flags_next = cse_pkg::incdec_flags(mem_inc, mem_inc[3:0] == 4'h0,
                                                       flags_reg[0]);
                end else begin
                    a_next = rdata_reg;
                end
            end
            S_DONE: begin
                // Publish the result once the output register is free.
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.prog_counter = pc_reg;
                    m_data_next.stack_ptr    = sp_reg;
                    m_data_next.accum        = a_reg;
                    m_data_next.pair_bc      = bc_reg;
                    m_data_next.pair_de      = de_reg;
                    m_data_next.pair_hl      = hl_reg;
                    m_data_next.flag_bits    = flags_reg;
                    m_data_next.state_count  = count_reg;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, architectural registers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= 16'd0;
            sp_reg      <= 16'd0;
            bc_reg      <= 16'd0;
            de_reg      <= 16'd0;
            hl_reg      <= 16'd0;
            a_reg       <= 8'd0;
            flags_reg   <= 5'd0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            sp_reg      <= sp_next;
            bc_reg      <= bc_next;
            de_reg      <= de_next;
            hl_reg      <= hl_next;
            a_reg       <= a_next;
            flags_reg   <= flags_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
        count_reg  <= count_next;
        op_reg     <= op_next;
        b1_reg     <= b1_next;
        m_data_reg <= m_data_next;
    end
endmodule

[src/cpu8080_subset_executor.sv]
// Top level of the 8080 subset executor: front end, queue and execution unit.
// A load goes from idle to done in the execution unit; an execute also passes B1,
// B2 and execute between them, with a memory read state added for LDAX and INR M,
// set by the single memory port that reads the opcode and two operand bytes in turn
// and then makes the data access. A halted execute goes to done. A two-entry
// queue in front lets input transfers arrive while an instruction runs, and the
// result register lets the next item start while a result waits to be taken.
module cpu8080_subset_executor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cse_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cse_pkg::out_item_t m_data
);
    logic                  q_valid;
    logic                  q_ready;
    cse_pkg::queue_entry_t q_entry;

    // Input side.
    cse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry)
    );

    // Execution side.
    cse_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    // A result that is not ok never reports clock states.
    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != cse_pkg::ST_OK) |-> m_data.state_count == 4'd0)
        else $error("non-ok result carries clock states");

    // Once halted by an unknown opcode, the next result is never ok.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_data.status == cse_pkg::ST_UNIMP)
        |=> !m_valid || (m_data.status == cse_pkg::ST_HALTED))
        else $error("halt did not stick");

    // Clock states never exceed the longest instruction.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.state_count <= 4'd10)
        else $error("clock state count out of range");
`endif
endmodule

[tb/sv/cse_checker.sv]
// Checker for the 8080 subset executor: predicts each result and compares it.
module cse_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cse_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cse_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending_results
);
    import cse_pkg::*;

    // Bit positions in the flag word.
    localparam int FL_CY = 0;
    localparam int FL_P  = 1;
    localparam int FL_AC = 2;
    localparam int FL_Z  = 3;
    localparam int FL_S  = 4;

    // Shadow copy of the machine state.
    logic [7:0]  mem_shadow [0:MEM_DEPTH-1];
    logic [15:0] pc_q;
    logic [15:0] sp_q;
    logic [7:0]  rb, rc, rd, re, rh, rl, ra;
    logic [4:0]  fl;
    logic        halted_q;
    out_item_t   expected_q[$];
    int          result_idx;

    // Increment or decrement one byte and update S, Z, AC and P; CY is kept.
    task automatic bump(inout logic [7:0] v, input logic down);
        logic [7:0] r;
        logic       ac;
        r  = down ? v - 8'd1 : v + 8'd1;
        ac = down ? (r[3:0] != 4'hF) : (r[3:0] == 4'h0);
        fl[FL_S]  = r[7];
        fl[FL_Z]  = (r == 8'h00);
        fl[FL_AC] = ac;
        fl[FL_P]  = ~^r;
        v = r;
    endtask

    // Execute the instruction at the program counter; zero states means unimplemented.
    task automatic run_instr(output logic [3:0] states);
        logic [15:0] at;
        logic [15:0] len;
        logic [16:0] sum;
        logic [7:0]  op, b1, b2, v;
        at = pc_q;
        op = mem_shadow[at];
        b1 = mem_shadow[at + 16'd1];
        b2 = mem_shadow[at + 16'd2];
        len = 16'd1;
        states = 4'd0;
        case (op)
            OP_NOP0, OP_NOP1, OP_NOP2, OP_NOP3,
            OP_NOP4, OP_NOP5, OP_NOP6, OP_NOP7: states = 4'd4;
            OP_LXI_B:  begin {rb, rc} = {b2, b1}; len = 16'd3; states = 4'd10; end
            OP_LXI_D:  begin {rd, re} = {b2, b1}; len = 16'd3; states = 4'd10; end
            OP_LXI_H:  begin {rh, rl} = {b2, b1}; len = 16'd3; states = 4'd10; end
            OP_LXI_SP: begin sp_q = {b2, b1}; len = 16'd3; states = 4'd10; end
            OP_STAX_B: begin mem_shadow[{rb, rc}] = ra; states = 4'd7; end
            OP_STAX_D: begin mem_shadow[{rd, re}] = ra; states = 4'd7; end
            OP_LDAX_B: begin ra = mem_shadow[{rb, rc}]; states = 4'd7; end
            OP_LDAX_D: begin ra = mem_shadow[{rd, re}]; states = 4'd7; end
            OP_INX_B:  begin {rb, rc} = {rb, rc} + 16'd1; states = 4'd5; end
            OP_INX_D:  begin {rd, re} = {rd, re} + 16'd1; states = 4'd5; end
            OP_DCX_B:  begin {rb, rc} = {rb, rc} - 16'd1; states = 4'd5; end
            OP_DCX_D:  begin {rd, re} = {rd, re} - 16'd1; states = 4'd5; end
            OP_INR_B:  begin bump(rb, 1'b0); states = 4'd5; end
            OP_INR_C:  begin bump(rc, 1'b0); states = 4'd5; end
            OP_INR_D:  begin bump(rd, 1'b0); states = 4'd5; end
            OP_INR_E:  begin bump(re, 1'b0); states = 4'd5; end
            OP_INR_H:  begin bump(rh, 1'b0); states = 4'd5; end
            OP_INR_L:  begin bump(rl, 1'b0); states = 4'd5; end
            OP_INR_A:  begin bump(ra, 1'b0); states = 4'd5; end
            OP_INR_M: begin
                v = mem_shadow[{rh, rl}];
                bump(v, 1'b0);
                mem_shadow[{rh, rl}] = v;
                states = 4'd10;
            end
            OP_DCR_B:  begin bump(rb, 1'b1); states = 4'd5; end
            OP_DCR_C:  begin bump(rc, 1'b1); states = 4'd5; end
            OP_DCR_D:  begin bump(rd, 1'b1); states = 4'd5; end
            OP_DCR_E:  begin bump(re, 1'b1); states = 4'd5; end
            OP_MVI_B:  begin rb = b1; len = 16'd2; states = 4'd7; end
            OP_MVI_C:  begin rc = b1; len = 16'd2; states = 4'd7; end
            OP_MVI_D:  begin rd = b1; len = 16'd2; states = 4'd7; end
            OP_MVI_E:  begin re = b1; len = 16'd2; states = 4'd7; end
            OP_RLC: begin
                fl[FL_CY] = ra[7];
                ra = {ra[6:0], ra[7]};
                states = 4'd4;
            end
            OP_RRC: begin
                fl[FL_CY] = ra[0];
                ra = {ra[0], ra[7:1]};
                states = 4'd4;
            end
            OP_RAL: begin
                v = ra;
                ra = {v[6:0], fl[FL_CY]};
                fl[FL_CY] = v[7];
                states = 4'd4;
            end
            OP_RAR: begin
                v = ra;
                ra = {fl[FL_CY], v[7:1]};
                fl[FL_CY] = v[0];
                states = 4'd4;
            end
            OP_DAD_B, OP_DAD_D: begin
                sum = {1'b0, rh, rl} + {1'b0, (op == OP_DAD_D) ? {rd, re} : {rb, rc}};
                fl[FL_CY] = sum[16];
                {rh, rl} = sum[15:0];
                states = 4'd10;
            end
            OP_MOV_BC: begin rb = rc; states = 4'd5; end
            OP_MOV_BD: begin rb = rd; states = 4'd5; end
            OP_MOV_BE: begin rb = re; states = 4'd5; end
            default: states = 4'd0;
        endcase
        if (states != 4'd0) begin
            pc_q = at + len;
        end
    endtask

    // Apply one accepted input transfer and form the result it should produce.
    task automatic predict_step(input in_item_t it, output out_item_t r);
        logic [3:0] states;
        logic [1:0] st;
        states = 4'd0;
        st = ST_OK;
        if (it.kind == KIND_LOAD) begin
            mem_shadow[it.load_address] = it.load_data;
            st = halted_q ? ST_HALTED : ST_OK;
        end else if (halted_q) begin
            st = ST_HALTED;
        end else begin
            run_instr(states);
            if (states == 4'd0) begin
                halted_q = 1'b1;
                st = ST_UNIMP;
            end
        end
        r.status       = st;
        r.prog_counter = pc_q;
        r.stack_ptr    = sp_q;
        r.accum        = ra;
        r.pair_bc      = {rb, rc};
        r.pair_de      = {rd, re};
        r.pair_hl      = {rh, rl};
        r.flag_bits    = fl;
        r.state_count  = states;
    endtask

    // One line per mismatch, and a count of them.
    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h, wanted 0x%0h",
                 result_idx, what, got, want);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report(what, got, want);
        end
    endtask

    // Track both channels; results are compared against the oldest prediction.
    always @(posedge aclk) begin
        out_item_t w;
        if (!aresetn) begin
            pc_q = '0;
            sp_q = '0;
            {rb, rc, rd, re, rh, rl, ra} = '0;
            fl = '0;
            halted_q = 1'b0;
            expected_q.delete();
            fail_count = 0;
            result_idx = 0;
            pending_results = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transfer", 16'd0, 16'd0);
                end else begin
                    w = expected_q.pop_front();
                    compare_field("status", 16'(m_data.status), 16'(w.status));
                    compare_field("prog_counter", m_data.prog_counter, w.prog_counter);
                    compare_field("stack_ptr", m_data.stack_ptr, w.stack_ptr);
                    compare_field("accum", 16'(m_data.accum), 16'(w.accum));
                    compare_field("pair_bc", m_data.pair_bc, w.pair_bc);
                    compare_field("pair_de", m_data.pair_de, w.pair_de);
                    compare_field("pair_hl", m_data.pair_hl, w.pair_hl);
                    compare_field("flag_bits", 16'(m_data.flag_bits), 16'(w.flag_bits));
                    compare_field("state_count", 16'(m_data.state_count),
                                  16'(w.state_count));
                end
                result_idx++;
            end
            if (s_valid && s_ready) begin
                predict_step(s_data, w);
                expected_q.push_back(w);
            end
            pending_results = expected_q.size();
        end
    end

endmodule

[tb/sv/tb_cpu8080_subset_executor.sv]
// Testbench top for the 8080 subset executor: stimulus, pacing and verdict.
module tb_cpu8080_subset_executor;
    import cse_pkg::*;

    localparam int NUM_IMPL = 45;
    localparam logic [7:0] IMPL_OPS [0:NUM_IMPL-1] = '{
        OP_NOP0, OP_NOP1, OP_NOP2, OP_NOP3, OP_NOP4, OP_NOP5, OP_NOP6, OP_NOP7,
        OP_LXI_B, OP_LXI_D, OP_LXI_H, OP_LXI_SP, OP_STAX_B, OP_STAX_D,
        OP_LDAX_B, OP_LDAX_D, OP_INX_B, OP_INX_D, OP_DCX_B, OP_DCX_D,
        OP_INR_B, OP_INR_C, OP_INR_D, OP_INR_E, OP_INR_H, OP_INR_L, OP_INR_M, OP_INR_A,
        OP_DCR_B, OP_DCR_C, OP_DCR_D, OP_DCR_E, OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E,
        OP_RLC, OP_RRC, OP_RAL, OP_RAR, OP_DAD_B, OP_DAD_D,
        OP_MOV_BC, OP_MOV_BD, OP_MOV_BE
    };
    localparam int ITEMS_PER_PHASE = 450;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    int         fail_count;
    int         pending_results;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          n_loads;
    int          n_execs;
    logic [15:0] code_base;
    logic [7:0]  code_q[$];
    logic [15:0] data_addr_q[$];
    logic [7:0]  data_val_q[$];
    int          instr_cnt;

    cpu8080_subset_executor i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cse_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Operand values biased toward the extremes.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: pick_word = 16'h0000;
            1: pick_word = 16'hFFFF;
            2: pick_word = 16'h8000;
            3: pick_word = 16'h7FFF;
            default: pick_word = 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: pick_byte = 8'h00;
            1: pick_byte = 8'hFF;
            2: pick_byte = 8'h7F;
            3: pick_byte = 8'h0F;
            default: pick_byte = 8'($urandom);
        endcase
    endfunction

    function automatic bit is_impl(input logic [7:0] op);
        is_impl = 1'b0;
        foreach (IMPL_OPS[i]) begin
            if (IMPL_OPS[i] == op) is_impl = 1'b1;
        end
    endfunction

    // One input transfer, with random idle cycles ahead of it.
    task automatic send(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.kind == KIND_LOAD) n_loads++;
        else n_execs++;
    endtask

    task automatic load_byte(input logic [15:0] addr, input logic [7:0] val);
        in_item_t it;
        it.kind = KIND_LOAD;
        it.load_address = addr;
        it.load_data = val;
        send(it);
    endtask

    // The address and data fields are don't-care on an execute, so they are random.
    task automatic exec_instr();
        in_item_t it;
        it.kind = KIND_EXEC;
        it.load_address = 16'($urandom);
        it.load_data = 8'($urandom);
        send(it);
    endtask

    task automatic add_op(input logic [7:0] op, input int nbytes,
                          input logic [7:0] b1, input logic [7:0] b2);
        code_q.push_back(op);
        if (nbytes > 1) code_q.push_back(b1);
        if (nbytes > 2) code_q.push_back(b2);
        instr_cnt++;
    endtask

    // Memory ops get their pointer set just before, aimed at the data area above
    // the program, so reads only ever hit bytes that were loaded.
    task automatic add_mem_op(input logic [7:0] op, input logic [15:0] addr);
        logic [7:0] lxi;
        case (op)
            OP_STAX_B, OP_LDAX_B: lxi = OP_LXI_B;
            OP_STAX_D, OP_LDAX_D: lxi = OP_LXI_D;
            default:              lxi = OP_LXI_H;
        endcase
        add_op(lxi, 3, addr[7:0], addr[15:8]);
        add_op(op, 1, 8'h00, 8'h00);
        if (op != OP_STAX_B && op != OP_STAX_D) begin
            data_addr_q.push_back(addr);
            data_val_q.push_back(pick_byte());
        end
    endtask

    function automatic logic [15:0] pick_data_addr();
        case ($urandom_range(5))
            0: pick_data_addr = 16'hFFFF;
            1: pick_data_addr = 16'h8000;
            default: pick_data_addr = 16'($urandom_range(16'h8000, 16'hFFFF));
        endcase
    endfunction

    // Load the pending program, two bytes past its end and its data, then run it.
    task automatic flush_program();
        int len;
        len = code_q.size();
        foreach (code_q[i]) load_byte(code_base + 16'(i), code_q[i]);
        load_byte(code_base + 16'(len), pick_byte());
        load_byte(code_base + 16'(len + 1), pick_byte());
        foreach (data_addr_q[i]) load_byte(data_addr_q[i], data_val_q[i]);
        repeat (instr_cnt) exec_instr();
        code_base = code_base + 16'(len);
        code_q.delete();
        data_addr_q.delete();
        data_val_q.delete();
        instr_cnt = 0;
    endtask

    task automatic add_random_op();
        logic [7:0]  op;
        logic [15:0] w;
        op = IMPL_OPS[$urandom_range(NUM_IMPL - 1)];
        w = pick_word();
        case (op)
            OP_LXI_B, OP_LXI_D, OP_LXI_H, OP_LXI_SP: add_op(op, 3, w[7:0], w[15:8]);
            OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E:  add_op(op, 2, pick_byte(), 8'h00);
            OP_STAX_B, OP_STAX_D, OP_LDAX_B, OP_LDAX_D, OP_INR_M:
                add_mem_op(op, pick_data_addr());
            default: add_op(op, 1, 8'h00, 8'h00);
        endcase
    endtask

    initial begin
        logic [7:0] bad_op;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        send_idle_pct = 18;
        recv_idle_pct = 71;
        n_loads = 0;
        n_execs = 0;
        code_base = 16'h0000;
        instr_cnt = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: counter wraps, flag corners, carries, rotates and moves.
        add_op(OP_MVI_B, 2, 8'hFF, 8'h00);
        add_op(OP_INR_B, 1, 8'h00, 8'h00);
        add_op(OP_DCR_C, 1, 8'h00, 8'h00);
        add_op(OP_MVI_D, 2, 8'h0F, 8'h00);
        add_op(OP_INR_D, 1, 8'h00, 8'h00);
        add_op(OP_INR_A, 1, 8'h00, 8'h00);
        add_op(OP_LXI_B, 3, 8'hFF, 8'hFF);
        add_op(OP_INX_B, 1, 8'h00, 8'h00);
        add_op(OP_DCX_D, 1, 8'h00, 8'h00);
        add_op(OP_LXI_H, 3, 8'hFF, 8'hFF);
        add_op(OP_DAD_D, 1, 8'h00, 8'h00);
        add_op(OP_RAR, 1, 8'h00, 8'h00);
        add_op(OP_RRC, 1, 8'h00, 8'h00);
        add_op(OP_RAL, 1, 8'h00, 8'h00);
        add_op(OP_RLC, 1, 8'h00, 8'h00);
        add_op(OP_MOV_BD, 1, 8'h00, 8'h00);
        add_op(OP_NOP7, 1, 8'h00, 8'h00);
        add_mem_op(OP_INR_M, 16'hFFFF);
        flush_program();

        // Random programs under three pacing patterns.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 18 : 0;
            while (n_loads + n_execs < (phase + 1) * ITEMS_PER_PHASE + 60) begin
                // Stray loads anywhere in memory ahead of each program.
                repeat ($urandom_range(2)) load_byte(16'($urandom), 8'($urandom));
                repeat ($urandom_range(1, 8)) add_random_op();
                flush_program();
            end
        end

        // Halt on an unimplemented opcode, then execute and load while halted.
        bad_op = OP_MOV_BC - 8'd1;
        if ($urandom_range(1) == 1) begin
            do bad_op = 8'($urandom); while (is_impl(bad_op));
        end
        add_op(bad_op, 1, 8'h00, 8'h00);
        flush_program();
        repeat (3) exec_instr();
        repeat (3) load_byte(16'($urandom), 8'($urandom));
        s_valid <= 1'b0;

        while (pending_results != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d memory loads and %0d instruction executes over three pacing",
                 n_loads, n_execs);
        $display("patterns, ending with a halt on opcode 0x%02h.", bad_op);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
src/cse_pkg.sv
src/cse_front.sv
src/cse_back.sv
src/cpu8080_subset_executor.sv
tb/sv/cse_checker.sv
tb/sv/tb_cpu8080_subset_executor.sv
